### src/rtu_mt_pkg.sv
// types, codes and crc step shared by the transaction engine modules
`timescale 1ns / 1ps
package rtu_mt_pkg;

  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_RSP  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEND = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_RX     = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [1:0]  RLEN_MAX    = 2'd3;

  localparam int MAX_RES = 4;
  localparam int IDX_W   = 2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       last;
  } rtu_mt_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       end_of_run;
  } rtu_mt_res_t;

  typedef struct packed {
    logic [IDX_W-1:0]          last_idx;
    rtu_mt_res_t [MAX_RES-1:0] res;
  } rtu_mt_job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/rtu_master_transaction_top.sv
// top level of the modbus rtu master transaction engine
//
//  channel  ports                        handshake
//  request  in_req                       push / full
//  result   out_res                      empty / pop
//  config   cfg_wdata (timeout_ticks)    cfg_we
//
// the front takes one request per cycle while full is low and turns it into a job
// of up to four results; the back hands out one result per cycle while results are popped
// and retires a job once its last result is loaded; results go through the job queue
// and then the back's output register; the job queue (JOB_DEPTH entries) absorbs bursts
// full follows the job queue; synchronous active-low reset; no clearing pass
`timescale 1ns / 1ps
module rtu_master_transaction_top
  import rtu_mt_pkg::*;
#(
  parameter int TIMER_BITS = 16,
  parameter int JOB_DEPTH  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  rtu_mt_req_t in_req,
  output logic        empty,
  input  logic        pop,
  output rtu_mt_res_t out_res,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        accept;
  logic        job_push;
  rtu_mt_job_t job_in, job_out;
  logic        q_full, q_empty, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  rtu_mt_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .req      (in_req),
    .job_push (job_push),
    .job      (job_in)
  );

  rtu_mt_queue #(
    .DEPTH(JOB_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_data(job_in),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(job_out),
    .empty  (q_empty)
  );

  rtu_mt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_job  (job_out),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .out_res(out_res)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !q_full)
    else $error("job pushed into full queue");

  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_res.kind == KIND_STATUS)) |-> out_res.end_of_run)
    else $error("status result not marked end of run");

  a_pop_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> job_out.res[job_out.last_idx].end_of_run)
    else $error("job retired without end of run result");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result pending after reset");
`endif

endmodule

### src/rtu_mt_front.sv
// front part: request classification, phase, crc and timer, job building
`timescale 1ns / 1ps
module rtu_mt_front
  import rtu_mt_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        accept,
  input  rtu_mt_req_t req,
  output logic        job_push,
  output rtu_mt_job_t job
);

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [1:0]            phase_r, phase_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [1:0]            rlen_r, rlen_nxt;
  logic [15:0]           timeout_r;

  logic [1:0]            ph;
  logic [15:0]           crc_base, crc_upd;
  logic [TIMER_BITS-1:0] el_base, el_inc;
  logic [CW-1:0]         to_ext;
  logic [2:0]            n_res;

  assign to_ext = CW'(timeout_r);

  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    elapsed_nxt = elapsed_r;
    rlen_nxt    = rlen_r;
    job         = '0;
    n_res       = 3'd0;
    ph          = phase_r;
    crc_base    = crc_r;
    el_base     = elapsed_r;
    el_inc      = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
    crc_upd     = crc_byte(crc_base, req.data_byte);
    case (req.op)
      OP_CMD: begin
        if (phase_r == PH_IDLE) begin
          ph       = PH_SEND;
          crc_base = CRC_INIT;
          el_base  = '0;
        end
        crc_upd     = crc_byte(crc_base, req.data_byte);
        elapsed_nxt = el_base;
        phase_nxt   = ph;
        if (ph == PH_SEND) begin
          job.res[0] = '{kind: KIND_TX, out_byte: req.data_byte, status: ST_OK,
                         end_of_run: 1'b0};
          crc_nxt    = crc_upd;
          n_res      = 3'd1;
          if (req.last) begin
            job.res[1] = '{kind: KIND_TX, out_byte: crc_upd[7:0], status: ST_OK,
                           end_of_run: 1'b0};
            job.res[2] = '{kind: KIND_TX, out_byte: crc_upd[15:8], status: ST_OK,
                           end_of_run: 1'b0};
            crc_nxt    = CRC_INIT;
            rlen_nxt   = 2'd0;
            if (CW'(el_base) >= to_ext) begin
              job.res[3] = '{kind: KIND_STATUS, out_byte: 8'h00, status: ST_TIMEOUT,
                             end_of_run: 1'b0};
              n_res      = 3'd4;
              phase_nxt  = PH_IDLE;
            end else begin
              n_res     = 3'd3;
              phase_nxt = PH_WAIT;
            end
          end
        end
      end
      OP_RSP: begin
        if (phase_r == PH_WAIT) begin
          job.res[0] = '{kind: KIND_RX, out_byte: req.data_byte, status: ST_OK,
                         end_of_run: 1'b0};
          crc_nxt    = crc_upd;
          rlen_nxt   = (rlen_r == RLEN_MAX) ? rlen_r : rlen_r + 2'd1;
          n_res      = 3'd1;
          if (req.last) begin
            job.res[1] = '{kind: KIND_STATUS, out_byte: 8'h00,
                           status: ((crc_upd == 16'h0000) && (rlen_nxt == RLEN_MAX))
                                   ? ST_OK : ST_CRC,
                           end_of_run: 1'b0};
            n_res      = 3'd2;
            phase_nxt  = PH_IDLE;
          end
        end
      end
      OP_TICK: begin
        if ((phase_r == PH_SEND) || (phase_r == PH_WAIT)) begin
          elapsed_nxt = el_inc;
          if ((phase_r == PH_WAIT) && (CW'(el_inc) >= to_ext)) begin
            job.res[0] = '{kind: KIND_STATUS, out_byte: 8'h00, status: ST_TIMEOUT,
                           end_of_run: 1'b0};
            n_res      = 3'd1;
            phase_nxt  = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
    job.last_idx = IDX_W'(n_res - 3'd1);
    if (n_res != 3'd0) begin
      job.res[job.last_idx].end_of_run = 1'b1;
    end
  end

  assign job_push = accept && (n_res != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      crc_r     <= CRC_INIT;
      elapsed_r <= '0;
      rlen_r    <= 2'd0;
      timeout_r <= TIMEOUT_RST;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        crc_r     <= crc_nxt;
        elapsed_r <= elapsed_nxt;
        rlen_r    <= rlen_nxt;
      end
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

endmodule

### src/rtu_mt_queue.sv
// job queue between front and back parts
`timescale 1ns / 1ps
module rtu_mt_queue
  import rtu_mt_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  rtu_mt_job_t wr_data,
  output logic        full,
  input  logic        rd_en,
  output rtu_mt_job_t rd_data,
  output logic        empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtu_mt_job_t      mem [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### src/rtu_mt_back.sv
// back part: job results into the output register, one per cycle unless stalled
`timescale 1ns / 1ps
module rtu_mt_back
  import rtu_mt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  rtu_mt_job_t q_job,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output rtu_mt_res_t out_res
);

  logic             out_valid_r;
  rtu_mt_res_t      out_res_r;
  logic [IDX_W-1:0] idx_r;
  logic             load;

  assign load    = (!out_valid_r || pop) && !q_empty;
  assign q_pop   = load && (idx_r == q_job.last_idx);
  assign empty   = !out_valid_r;
  assign out_res = out_res_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= q_job.res[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= q_pop ? '0 : idx_r + 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
